>>> rtl/trbr_pkg.sv
`timescale 1ns / 1ps

package trbr_pkg;

    // Register map: index of each register, byte address is 4 * index
    localparam int unsigned ADDR_W = 4;
    localparam logic [1:0] REG_FRAMING_MASK = 2'd0;
    localparam logic [1:0] REG_ZERO_POINT   = 2'd1;
    localparam logic [1:0] REG_STEP         = 2'd2;

    // Reset values of the registers
    localparam logic [7:0]         FRAMING_MASK_RST = 8'h01;
    localparam logic signed [19:0] ZERO_POINT_RST   = 20'sh00000;
    localparam logic [23:0]        STEP_RST         = 24'h010000;

    // Complement check: upper nibble of the second byte against bits 4:1 of the first
    localparam logic [7:0] CHECK_MASK    = 8'hF0;
    localparam logic [7:0] CHECK_COPY    = 8'h1E;
    localparam logic [7:0] CHECK_PATTERN = 8'hF0;

    // Scale point bit fields in the first and second byte
    localparam logic [7:0] POINT_LO_MASK = 8'hE0;
    localparam logic [7:0] POINT_HI_MASK = 8'hFE;

    typedef struct packed {
        logic [7:0]         framing_mask;
        logic signed [19:0] zero_point;
        logic [23:0]        step;
    } t_cfg;

endpackage

>>> rtl/trbr_if.sv
`timescale 1ns / 1ps

// Byte channel from the serial link
interface trbr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// Decoded message channel
interface trbr_out_if;
    logic               valid;
    logic               ready;
    logic [7:0]         first_byte;
    logic [7:0]         second_byte;
    logic               interpreted;
    logic               check_ok;
    logic [9:0]         scale_point;
    logic signed [47:0] current_value;
    logic [31:0]        wrong_total;
    logic [31:0]        incomplete_total;
    logic [31:0]        message_total;

    modport source (
        output valid, output first_byte, output second_byte, output interpreted,
        output check_ok, output scale_point, output current_value,
        output wrong_total, output incomplete_total, output message_total,
        input ready
    );
    modport sink (
        input valid, input first_byte, input second_byte, input interpreted,
        input check_ok, input scale_point, input current_value,
        input wrong_total, input incomplete_total, input message_total,
        output ready
    );
endinterface

>>> rtl/two_byte_reading_receiver.sv
`timescale 1ns / 1ps

// Two-byte reading receiver: takes one link byte per beat on i_in and, for each
// completed byte pair, returns one beat on o_out carrying both bytes, the
// complement check result, the decoded 10-bit scale point, the current
// (point * 256 - zero_point) * step in signed Q.24, and the wrong, incomplete
// and message counters as they stand after that pair. A byte with
// (rx_byte & framing_mask) == 0 starts a message; bytes that do not complete a
// pair give no output beat. One byte is accepted every cycle unless a stalled
// result holds the input: each byte passes through an input register, a single
// stage of decode and a 21 x 25 bit multiply, and into the result register that
// drives o_out. A stalled result holds the input only when the byte behind it
// would complete another pair. Registers sit at byte addresses 0x0
// (framing_mask), 0x4 (zero_point) and 0x8 (step) and should be written while
// no bytes are in flight.
module two_byte_reading_receiver (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [trbr_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    trbr_in_if.sink                     i_in,
    trbr_out_if.source                  o_out
);
    import trbr_pkg::*;

    t_cfg w_cfg;

    // Configuration registers
    trbr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Framing, check and decode
    trbr_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_in    (i_in),
        .o_out   (o_out)
    );

endmodule

>>> rtl/trbr_cfg.sv
`timescale 1ns / 1ps

module trbr_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [trbr_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output trbr_pkg::t_cfg              o_cfg
);
    import trbr_pkg::*;

    t_cfg       r_cfg;
    logic       w_wr;
    logic [1:0] w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[3:2];

    // Write the addressed register at the access cycle, drop writes past the map
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.framing_mask <= FRAMING_MASK_RST;
            r_cfg.zero_point   <= ZERO_POINT_RST;
            r_cfg.step         <= STEP_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_FRAMING_MASK: r_cfg.framing_mask <= pwdata[7:0];
                REG_ZERO_POINT:   r_cfg.zero_point   <= $signed(pwdata[19:0]);
                REG_STEP:         r_cfg.step         <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb begin
        unique case (w_idx)
            REG_FRAMING_MASK: prdata = {24'd0, r_cfg.framing_mask};
            REG_ZERO_POINT:   prdata = {12'd0, r_cfg.zero_point};
            REG_STEP:         prdata = {8'd0, r_cfg.step};
            default:          prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

>>> rtl/trbr_core.sv
`timescale 1ns / 1ps

module trbr_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  trbr_pkg::t_cfg i_cfg,
    trbr_in_if.sink        i_in,
    trbr_out_if.source     o_out
);
    import trbr_pkg::*;

    // Input register
    logic               r_in_valid;
    logic [7:0]         r_in_byte;
    // Framing state and counters
    logic               r_pair_held;
    logic               r_start_seen;
    logic [7:0]         r_held_byte;
    logic [31:0]        r_msg_cnt;
    logic [31:0]        r_inc_cnt;
    logic [31:0]        r_wrong_cnt;
    // Result register
    logic               r_out_valid;
    logic [7:0]         r_first;
    logic [7:0]         r_second;
    logic               r_interp;
    logic               r_ok;
    logic [9:0]         r_point;
    logic signed [47:0] r_current;
    logic [31:0]        r_wrong_tot;
    logic [31:0]        r_inc_tot;
    logic [31:0]        r_msg_tot;

    logic               w_is_start;
    logic               w_complete;
    logic               w_proc;
    logic [7:0]         w_check_word;
    logic               w_ok;
    logic [9:0]         w_point;
    logic signed [20:0] w_diff;
    logic signed [45:0] w_prod;
    logic [31:0]        n_msg_cnt;
    logic [31:0]        n_inc_cnt;
    logic [31:0]        n_wrong_cnt;

    // Classify the held beat
    assign w_is_start = (r_in_byte & i_cfg.framing_mask) == 8'd0;
    assign w_complete = !w_is_start && r_pair_held;

    // Advance the beat unless its result would overwrite a stalled one
    assign w_proc     = r_in_valid && (!w_complete || !r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_proc;

    // Complement check and point decode
    assign w_check_word = (r_in_byte & CHECK_MASK) ^ 8'((r_held_byte & CHECK_COPY) << 3);
    assign w_ok         = r_start_seen && (w_check_word == CHECK_PATTERN);
    assign w_point      = 10'((r_held_byte & POINT_LO_MASK) >> 5)
                        | (10'(r_in_byte & POINT_HI_MASK) << 2);

    // Current: (point * 256 - zero) * step, exact
    assign w_diff = $signed({3'b000, w_point, 8'h00})
                  - $signed({i_cfg.zero_point[19], i_cfg.zero_point});
    assign w_prod = w_diff * $signed({1'b0, i_cfg.step});

    // Counter updates
    always_comb begin
        n_msg_cnt   = r_msg_cnt;
        n_inc_cnt   = r_inc_cnt;
        n_wrong_cnt = r_wrong_cnt;
        if (w_is_start && r_pair_held) begin
            n_inc_cnt = r_inc_cnt + 32'd1;
        end
        if (w_complete) begin
            n_msg_cnt = r_msg_cnt + 32'd1;
            if (r_start_seen) begin
                n_wrong_cnt = w_ok ? 32'd0 : r_wrong_cnt + 32'd1;
            end
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_byte <= i_in.rx_byte;
        end
    end

    // Framing state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pair_held  <= 1'b0;
            r_start_seen <= 1'b0;
            r_msg_cnt    <= 32'd0;
            r_inc_cnt    <= 32'd0;
            r_wrong_cnt  <= 32'd0;
        end else if (w_proc) begin
            r_msg_cnt   <= n_msg_cnt;
            r_inc_cnt   <= n_inc_cnt;
            r_wrong_cnt <= n_wrong_cnt;
            if (w_complete) begin
                r_pair_held  <= 1'b0;
                r_start_seen <= 1'b0;
            end else begin
                r_pair_held <= 1'b1;
                if (w_is_start) begin
                    r_start_seen <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proc && !w_complete) begin
            r_held_byte <= r_in_byte;
        end
    end

    // Result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_proc && w_complete) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register payload
    always_ff @(posedge i_clk) begin
        if (w_proc && w_complete) begin
            r_first     <= r_held_byte;
            r_second    <= r_in_byte;
            r_interp    <= r_start_seen;
            r_ok        <= w_ok;
            r_point     <= w_ok ? w_point : 10'd0;
            r_current   <= w_ok ? {{2{w_prod[45]}}, w_prod} : 48'sd0;
            r_wrong_tot <= n_wrong_cnt;
            r_inc_tot   <= n_inc_cnt;
            r_msg_tot   <= n_msg_cnt;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.first_byte       = r_first;
    assign o_out.second_byte      = r_second;
    assign o_out.interpreted      = r_interp;
    assign o_out.check_ok         = r_ok;
    assign o_out.scale_point      = r_point;
    assign o_out.current_value    = r_current;
    assign o_out.wrong_total      = r_wrong_tot;
    assign o_out.incomplete_total = r_inc_tot;
    assign o_out.message_total    = r_msg_tot;

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import trbr_pkg::*;

    // Index past the register map, used to show that such writes are ignored
    localparam logic [1:0] REG_SPARE = 2'd3;

    localparam int SETTLE_CYCLES    = 8;
    localparam int LONG_HOLD_CYCLES = 60;
    localparam int REPORT_LIMIT     = 10;

    typedef struct {
        logic [7:0]         first_byte;
        logic [7:0]         second_byte;
        logic               interpreted;
        logic               check_ok;
        logic [9:0]         scale_point;
        logic signed [47:0] current_value;
        logic [31:0]        wrong_total;
        logic [31:0]        incomplete_total;
        logic [31:0]        message_total;
    } t_msg;

    logic                i_clk;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    trbr_in_if  link_if ();
    trbr_out_if msg_if ();

    two_byte_reading_receiver DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_in    (link_if),
        .o_out   (msg_if)
    );

    // Shadow of the receiver: registers, pair tracking and counters
    t_cfg        shadow_cfg;
    bit          byte_held;
    bit          pair_started;
    logic [7:0]  held_first;
    logic [31:0] shadow_messages;
    logic [31:0] shadow_incomplete;
    logic [31:0] shadow_wrong;

    // Messages still owed by the receiver, oldest first
    t_msg expected_msgs[$];

    // Directed rows: byte, whether a result is typed in, and that result
    logic [7:0] dir_bytes[$];
    bit         dir_typed[$];
    t_msg       dir_results[$];

    t_msg blank_msg;

    int errors;
    int bytes_sent;
    int msgs_checked;
    int passes_seen;
    int settings_run;

    // Controls for the input-side gaps and the output-side ready process
    bit gaps_on;
    bit no_idle;
    bit long_hold;
    int hold_left;

    // Free-running clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop if the run hangs
    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic logic [ADDR_W-1:0] reg_addr(input logic [1:0] idx);
        return {idx, 2'b00};
    endfunction

    function automatic t_msg mk_msg(
        input logic [7:0]  f,
        input logic [7:0]  s,
        input logic        interp,
        input logic        ok,
        input logic [9:0]  point,
        input logic [47:0] cur,
        input logic [31:0] wrong,
        input logic [31:0] incomplete,
        input logic [31:0] total
    );
        t_msg m;
        m.first_byte       = f;
        m.second_byte      = s;
        m.interpreted      = interp;
        m.check_ok         = ok;
        m.scale_point      = point;
        m.current_value    = cur;
        m.wrong_total      = wrong;
        m.incomplete_total = incomplete;
        m.message_total    = total;
        return m;
    endfunction

    // Apply a register write to the shadow copy; unknown indexes drop
    function automatic void shadow_reg_write(input logic [1:0] idx, input logic [31:0] data);
        case (idx)
            REG_FRAMING_MASK: shadow_cfg.framing_mask = data[7:0];
            REG_ZERO_POINT:   shadow_cfg.zero_point   = data[19:0];
            REG_STEP:         shadow_cfg.step         = data[23:0];
            default: ;
        endcase
    endfunction

    // Track one link byte; returns 1 and fills m when it completes a pair
    function automatic bit decode_link_byte(input logic [7:0] b, output t_msg m);
        logic [7:0] first;
        logic [9:0] point;
        longint     zp;
        longint     diff;
        longint     prod;
        m = blank_msg;
        m.interpreted   = 1'b0;
        m.check_ok      = 1'b0;
        m.scale_point   = '0;
        m.current_value = '0;
        // A start byte drops any half-received pair
        if ((b & shadow_cfg.framing_mask) == 8'h00) begin
            if (byte_held)
                shadow_incomplete = shadow_incomplete + 32'd1;
            byte_held    = 1'b0;
            pair_started = 1'b1;
        end
        if (!byte_held) begin
            held_first = b;
            byte_held  = 1'b1;
            return 1'b0;
        end
        first = held_first;
        if (pair_started) begin
            if (((b & CHECK_MASK) ^ ((first & CHECK_COPY) << 3)) != CHECK_PATTERN) begin
                shadow_wrong = shadow_wrong + 32'd1;
            end else begin
                shadow_wrong = '0;
                point = {b[7:1], first[7:5]};
                zp    = {{44{shadow_cfg.zero_point[19]}}, shadow_cfg.zero_point};
                diff  = longint'({54'd0, point}) * 256 - zp;
                prod  = diff * longint'({40'd0, shadow_cfg.step});
                m.check_ok      = 1'b1;
                m.scale_point   = point;
                m.current_value = prod[47:0];
            end
        end
        shadow_messages    = shadow_messages + 32'd1;
        m.first_byte       = first;
        m.second_byte      = b;
        m.interpreted      = pair_started;
        m.wrong_total      = shadow_wrong;
        m.incomplete_total = shadow_incomplete;
        m.message_total    = shadow_messages;
        byte_held    = 1'b0;
        pair_started = 1'b0;
        return 1'b1;
    endfunction

    task automatic note_error(input string what);
        if (errors < REPORT_LIMIT)
            $display("mismatch: %s", what);
        errors++;
    endtask

    task automatic add_row(input logic [7:0] b);
        dir_bytes.push_back(b);
        dir_typed.push_back(1'b0);
        dir_results.push_back(blank_msg);
    endtask

    task automatic add_row_checked(input logic [7:0] b, input t_msg m);
        dir_bytes.push_back(b);
        dir_typed.push_back(1'b1);
        dir_results.push_back(m);
    endtask

    // Offer one byte, hold it until accepted, then maybe idle a burst
    task automatic send_byte(input logic [7:0] b, input bit typed, input t_msg given);
        t_msg pred;
        bit   made;
        link_if.valid   <= 1'b1;
        link_if.rx_byte <= b;
        do @(posedge i_clk); while (!link_if.ready);
        made = decode_link_byte(b, pred);
        bytes_sent++;
        if (made) begin
            if (typed)
                expected_msgs.push_back(given);
            else
                expected_msgs.push_back(pred);
        end
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            link_if.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= reg_addr(idx);
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        shadow_reg_write(idx, data);
    endtask

    // Wait until every owed message is in, then let the pipeline drain
    task automatic settle();
        while (expected_msgs.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Reprogram the block, read the registers back, then stream random bytes
    task automatic run_phase(
        input logic [7:0]  fmask,
        input logic [19:0] zp,
        input logic [23:0] stp,
        input int          n_items,
        input bit          pressure,
        input bit          poke_spare,
        input bit          quiet
    );
        logic [31:0] want[3];
        logic [31:0] keep[3];
        logic [31:0] got;
        logic [7:0]  a;
        logic [7:0]  c;
        int          sent;
        int          pick;
        settle();
        keep = '{32'h0000_00FF, 32'h000F_FFFF, 32'h00FF_FFFF};
        apb_write(REG_FRAMING_MASK, ($urandom() & ~keep[REG_FRAMING_MASK]) | {24'd0, fmask});
        apb_write(REG_ZERO_POINT, ($urandom() & ~keep[REG_ZERO_POINT]) | {12'd0, zp});
        apb_write(REG_STEP, ($urandom() & ~keep[REG_STEP]) | {8'd0, stp});
        if (poke_spare)
            apb_write(REG_SPARE, $urandom());
        want[REG_FRAMING_MASK] = {24'd0, shadow_cfg.framing_mask};
        want[REG_ZERO_POINT]   = {12'd0, shadow_cfg.zero_point};
        want[REG_STEP]         = {8'd0, shadow_cfg.step};
        // Read each register back over the same port
        for (int i = int'(REG_FRAMING_MASK); i <= int'(REG_STEP); i++) begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            paddr   <= reg_addr(i[1:0]);
            @(posedge i_clk);
            penable <= 1'b1;
            do @(posedge i_clk); while (!pready);
            got = prdata;
            psel    <= 1'b0;
            penable <= 1'b0;
            @(posedge i_clk);
            if ((got & keep[i]) !== want[i])
                note_error($sformatf("register %0d read %h, expected %h", i, got, want[i]));
        end
        settings_run++;

        if (quiet)
            no_idle = 1'b1;
        gaps_on = !quiet && !pressure;
        if (pressure)
            long_hold = 1'b1;

        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                // Well-formed pair, mostly with a passing complement check
                a = 8'($urandom_range(0, 255)) & ~shadow_cfg.framing_mask;
                c = 8'($urandom_range(0, 255));
                if ($urandom_range(0, 99) < 85)
                    c[7:4] = ~a[4:1];
                if ((c & shadow_cfg.framing_mask) == 8'h00)
                    c = c | (shadow_cfg.framing_mask & 8'h0F);
                send_byte(a, 1'b0, blank_msg);
                send_byte(c, 1'b0, blank_msg);
                sent += 2;
            end else if (pick < 85) begin
                // Two start bytes in a row break off a message
                send_byte(8'($urandom_range(0, 255)) & ~shadow_cfg.framing_mask, 1'b0,
                    blank_msg);
                send_byte(8'($urandom_range(0, 255)) & ~shadow_cfg.framing_mask, 1'b0,
                    blank_msg);
                sent += 2;
            end else begin
                send_byte(8'($urandom_range(0, 255)), 1'b0, blank_msg);
                sent += 1;
            end
        end
        link_if.valid <= 1'b0;
        gaps_on = !quiet;
    endtask

    // Output ready: random stall bursts, one long hold on request
    initial begin
        msg_if.ready <= 1'b0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (long_hold) begin
                long_hold = 1'b0;
                hold_left = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                msg_if.ready <= 1'b0;
                hold_left--;
            end else if (!no_idle && $urandom_range(0, 7) == 0) begin
                msg_if.ready <= 1'b0;
                hold_left = $urandom_range(0, 4);
            end else begin
                msg_if.ready <= 1'b1;
            end
        end
    end

    // Check every accepted message beat against the oldest expectation
    always @(posedge i_clk) begin
        t_msg got;
        t_msg want;
        if (i_rst_n && msg_if.valid && msg_if.ready) begin
            got.first_byte       = msg_if.first_byte;
            got.second_byte      = msg_if.second_byte;
            got.interpreted      = msg_if.interpreted;
            got.check_ok         = msg_if.check_ok;
            got.scale_point      = msg_if.scale_point;
            got.current_value    = msg_if.current_value;
            got.wrong_total      = msg_if.wrong_total;
            got.incomplete_total = msg_if.incomplete_total;
            got.message_total    = msg_if.message_total;
            msgs_checked++;
            if (got.check_ok === 1'b1)
                passes_seen++;
            if (expected_msgs.size() == 0) begin
                note_error($sformatf("unexpected message %p", got));
            end else begin
                want = expected_msgs.pop_front();
                if (got.first_byte !== want.first_byte
                        || got.second_byte !== want.second_byte
                        || got.interpreted !== want.interpreted
                        || got.check_ok !== want.check_ok
                        || got.scale_point !== want.scale_point
                        || got.current_value !== want.current_value
                        || got.wrong_total !== want.wrong_total
                        || got.incomplete_total !== want.incomplete_total
                        || got.message_total !== want.message_total)
                    note_error($sformatf("message %0d expected %p, got %p",
                        msgs_checked, want, got));
            end
        end
    end

    initial begin
        // Known values on every input from time zero
        i_rst_n         = 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        link_if.valid   <= 1'b0;
        link_if.rx_byte <= '0;
        errors       = 0;
        bytes_sent   = 0;
        msgs_checked = 0;
        passes_seen  = 0;
        settings_run = 1;
        gaps_on      = 1'b1;
        no_idle      = 1'b0;
        long_hold    = 1'b0;
        blank_msg    = mk_msg('0, '0, 1'b0, 1'b0, '0, '0, '0, '0, '0);

        // Shadow state after reset
        shadow_cfg.framing_mask = FRAMING_MASK_RST;
        shadow_cfg.zero_point   = ZERO_POINT_RST;
        shadow_cfg.step         = STEP_RST;
        byte_held         = 1'b0;
        pair_started      = 1'b0;
        held_first        = '0;
        shadow_messages   = '0;
        shadow_incomplete = '0;
        shadow_wrong      = '0;

        // Directed bytes under the reset register values
        add_row(8'h00);
        add_row_checked(8'hF1, mk_msg(8'h00, 8'hF1, 1'b1, 1'b1, 10'd960,
            48'h0003_C000_0000, 32'd0, 32'd0, 32'd1));
        add_row(8'hE0);
        add_row_checked(8'hFF, mk_msg(8'hE0, 8'hFF, 1'b1, 1'b1, 10'd1023,
            48'h0003_FF00_0000, 32'd0, 32'd0, 32'd2));
        // Failed complement check
        add_row(8'h00);
        add_row_checked(8'h01, mk_msg(8'h00, 8'h01, 1'b1, 1'b0, 10'd0,
            48'd0, 32'd1, 32'd0, 32'd3));
        // Pair with no start byte leaves the wrong count alone
        add_row(8'h01);
        add_row_checked(8'h01, mk_msg(8'h01, 8'h01, 1'b0, 1'b0, 10'd0,
            48'd0, 32'd1, 32'd0, 32'd4));
        // Start byte while one is held, then a passing pair
        add_row(8'h02);
        add_row(8'h04);
        add_row(8'hD1);
        add_row(8'hFE);
        add_row(8'h0F);
        // Two failures in a row
        add_row(8'h80);
        add_row(8'h81);
        add_row(8'h80);
        add_row(8'h81);
        // Held non-start byte broken off by a start byte
        add_row(8'h55);
        add_row(8'h54);
        add_row(8'h55);
        add_row(8'hAA);
        add_row(8'hFF);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < dir_bytes.size(); i++)
            send_byte(dir_bytes[i], dir_typed[i], dir_results[i]);
        link_if.valid <= 1'b0;

        // Extreme settings first, then random ones; the last runs flat out
        run_phase(8'hFF, 20'h80000, 24'hFF_FFFF, 200, 1'b1, 1'b0, 1'b0);
        run_phase(8'h00, 20'h12345, 24'h00_0001, 30, 1'b0, 1'b1, 1'b0);
        run_phase(8'h80, 20'h7FFFF, 24'h00_0000, 200, 1'b0, 1'b0, 1'b0);
        for (int k = 0; k < 3; k++)
            run_phase(8'($urandom_range(1, 255)), 20'($urandom()), 24'($urandom()), 280,
                1'b0, 1'b0, k == 2);

        settle();
        if (expected_msgs.size() != 0)
            note_error($sformatf("%0d messages never arrived", expected_msgs.size()));

        $display("covered %0d link bytes across %0d register settings", bytes_sent,
            settings_run);
        $display("checked %0d messages, %0d with a passing check, %0d broken off",
            msgs_checked, passes_seen, shadow_incomplete);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

>>> two_byte_reading_receiver.f
rtl/trbr_pkg.sv
rtl/trbr_if.sv
rtl/trbr_cfg.sv
rtl/trbr_core.sv
rtl/two_byte_reading_receiver.sv
verif/testbench.sv
